FILE: rtl/core/gfu_pkg.sv
// Shared types and constants for the GELU (tanh form) half-precision unit.
// No dependencies; imported by every module of the block.
package gfu_pkg;

  localparam int unsigned FRAC_BITS = 16;

  // fixed-point word widths along the polynomial path
  localparam int unsigned A_W   = FRAC_BITS + 3;
  localparam int unsigned P1_W  = 2 * A_W;
  localparam int unsigned A2_W  = FRAC_BITS + 6;
  localparam int unsigned P2_W  = A2_W + A_W;
  localparam int unsigned A3_W  = FRAC_BITS + 9;
  localparam int unsigned P3_W  = A3_W + 28;
  localparam int unsigned BB_W  = FRAC_BITS + 5;
  localparam int unsigned SUM_W = FRAC_BITS + 6;
  localparam int unsigned P4_W  = SUM_W + 33;
  localparam int unsigned Z_W   = FRAC_BITS + 7;
  localparam int unsigned P5_W  = Z_W + 33;
  localparam int unsigned U_W   = FRAC_BITS + 8;
  localparam int unsigned K_W   = U_W - FRAC_BITS;
  localparam int unsigned P6_W  = FRAC_BITS + 32;

  localparam logic [27:0] C_CUBE  = 28'd192049463;
  localparam logic [32:0] C_BIG   = 33'd6853776189;
  localparam logic [32:0] C_LOG2E = 33'd6196328019;
  localparam logic [31:0] C_LN2   = 32'd2977044472;

  localparam int unsigned HORNER_N = 12;
  localparam int unsigned DIV_BITS = 33;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] HALF_QNAN    = 16'h7E00;
  localparam logic [15:0] HALF_POS_INF = 16'h7C00;
  localparam logic [15:0] HALF_ZERO    = 16'h0000;

  typedef struct packed {
    logic        valid;
    logic        special;
    logic [15:0] spec_val;
    logic        sign;
    logic [4:0]  ee;
    logic [10:0] m;
    logic        last;
  } side_t;

  typedef struct packed {
    logic [A_W-1:0] a;
    side_t          side;
  } item_t;

endpackage

FILE: rtl/core/gfu_front.sv
// Front stage: decodes the half input, catches specials, forms |x| in fixed point.
// Depends on gfu_pkg.
module gfu_front import gfu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] x_half_i,
  input  logic        last_in_i,
  input  logic        qfull_i,
  output logic        qpush_o,
  output item_t       item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  adv;

  assign adv     = !valid_q || !qfull_i;
  assign full    = !adv;
  assign qpush_o = valid_q && !qfull_i;
  assign item_o  = item_q;

  always_comb begin
    logic [4:0]  ex;
    logic [9:0]  fr;
    logic [4:0]  ee;
    logic [10:0] m;
    logic [11:0] tmp;
    int          sh;
    ex  = x_half_i[14:10];
    fr  = x_half_i[9:0];
    ee  = (ex != 5'd0) ? ex : 5'd1;
    m   = (ex != 5'd0) ? {1'b1, fr} : {1'b0, fr};
    sh  = int'(ee) - 25 + int'(FRAC_BITS);
    tmp = '0;
    item_d.side.valid    = 1'b1;
    item_d.side.sign     = x_half_i[15];
    item_d.side.ee       = ee;
    item_d.side.m        = m;
    item_d.side.last     = last_in_i;
    item_d.side.special  = 1'b0;
    item_d.side.spec_val = HALF_ZERO;
    if (ex == 5'd31) begin
      item_d.side.special  = 1'b1;
      item_d.side.spec_val = (fr != 10'd0) ? HALF_QNAN :
                             (x_half_i[15] ? HALF_ZERO : HALF_POS_INF);
    end else if (ex >= 5'd18) begin
      item_d.side.special  = 1'b1;
      item_d.side.spec_val = x_half_i[15] ? HALF_ZERO : x_half_i;
    end
    if (sh >= 0) begin
      item_d.a = A_W'(m) << sh;
    end else begin
      tmp      = {m, 1'b0} >> (-sh);
      item_d.a = A_W'(tmp >> 1) + A_W'(tmp[0]);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (adv) begin
      valid_d = push;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && push) begin
      item_q <= item_d;
    end
  end

endmodule

FILE: rtl/core/gfu_queue.sv
// Short item queue between the front and the arithmetic back end.
// Depends on gfu_pkg.
module gfu_queue import gfu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  item_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/core/gfu_back.sv
// Back end: polynomial, exp by Horner, sigma by pipelined division, half packing.
// Depends on gfu_pkg; fed from gfu_queue.
module gfu_back import gfu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        qempty_i,
  input  item_t       qitem_i,
  output logic        qpop_o,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] y_half_o,
  output logic        last_out_o
);

  localparam int unsigned HS0 = 7;                       // first Horner stage
  localparam int unsigned ES  = HS0 + 2 * HORNER_N;      // exp scale stage
  localparam int unsigned NS_ = ES + 1;                  // numerator stage
  localparam int unsigned DS0 = NS_ + 1;                 // first divider stage
  localparam int unsigned MS  = DS0 + DIV_BITS;          // product stage
  localparam int unsigned NST = MS + 2;

  localparam logic [30:0] ONE30 = 31'd1 << 30;

  side_t side_q [NST];
  side_t side_in;
  logic  en;

  // output buffer, two entries
  logic [16:0] ob_q [2];
  logic        ob_wp_q, ob_rp_q;
  logic [1:0]  ob_cnt_q, ob_cnt_d;
  logic        ob_push, ob_pop;

  assign en     = (ob_cnt_q != 2'd2);
  assign qpop_o = en && !qempty_i;

  always_comb begin
    side_in       = qitem_i.side;
    side_in.valid = !qempty_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        side_q[i].valid <= 1'b0;
      end
    end else if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < NST; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // polynomial and exponent argument
  logic [P1_W-1:0]  p1_q;
  logic [P2_W-1:0]  p2_q;
  logic [P3_W-1:0]  p3_q;
  logic [P4_W-1:0]  p4_q;
  logic [P5_W-1:0]  p5_q;
  logic [P6_W-1:0]  p6_q;
  logic [A_W-1:0]   a0_q, a1_q, a2r_q;
  logic [K_W-1:0]   k5_q, k6_q;
  logic [29:0]      r6_q;
  logic [A2_W-1:0]  a2;
  logic [A3_W-1:0]  a3;
  logic [BB_W-1:0]  bb;
  logic [Z_W-1:0]   z;
  logic [U_W-1:0]   u;

  assign a2 = A2_W'((p1_q >> FRAC_BITS) + P1_W'(p1_q[FRAC_BITS-1]));
  assign a3 = A3_W'((p2_q >> FRAC_BITS) + P2_W'(p2_q[FRAC_BITS-1]));
  assign bb = BB_W'((p3_q >> 32) + P3_W'(p3_q[31]));
  assign z  = Z_W'((p4_q >> 32) + P4_W'(p4_q[31]));
  assign u  = U_W'((p5_q >> 32) + P5_W'(p5_q[31]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q  <= P1_W'(qitem_i.a) * P1_W'(qitem_i.a);
      a0_q  <= qitem_i.a;
      p2_q  <= P2_W'(a2) * P2_W'(a0_q);
      a1_q  <= a0_q;
      p3_q  <= P3_W'(a3) * P3_W'(C_CUBE);
      a2r_q <= a1_q;
      p4_q  <= P4_W'(SUM_W'(a2r_q) + SUM_W'(bb)) * P4_W'(C_BIG);
      p5_q  <= P5_W'(z) * P5_W'(C_LOG2E);
      p6_q  <= P6_W'(u[FRAC_BITS-1:0]) * P6_W'(C_LN2);
      k5_q  <= u[U_W-1:FRAC_BITS];
      r6_q  <= 30'((p6_q >> (FRAC_BITS + 2)) + P6_W'(p6_q[FRAC_BITS+1]));
      k6_q  <= k5_q;
    end
  end

  // exp(-r) by Horner, two stages a step: multiply, then divide by n via reciprocal
  logic [30:0]    pw_in [HORNER_N+1];
  logic [29:0]    hr_out [HORNER_N];
  logic [K_W-1:0] hk_out [HORNER_N];

  assign pw_in[0] = ONE30;

  for (genvar gi = 0; gi < HORNER_N; gi++) begin : g_horner
    localparam int unsigned NDIV = HORNER_N - gi;
    localparam int unsigned SHF  = 30 + $clog2(NDIV);
    localparam logic [63:0] MG   = ((64'd1 << SHF) + 64'(NDIV) - 64'd1) / 64'(NDIV);
    logic [29:0]    r_src, t_q, ra_q, rb_q;
    logic [K_W-1:0] k_src, ka_q, kb_q;
    logic [60:0]    prod, qm_q;
    if (gi == 0) begin : g_first
      assign r_src = r6_q;
      assign k_src = k6_q;
    end else begin : g_next
      assign r_src = hr_out[gi-1];
      assign k_src = hk_out[gi-1];
    end
    assign prod = 61'(r_src) * 61'(pw_in[gi]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        t_q  <= prod[59:30];
        ra_q <= r_src;
        ka_q <= k_src;
        qm_q <= 61'(t_q) * 61'(MG[30:0]);
        rb_q <= ra_q;
        kb_q <= ka_q;
      end
    end
    assign pw_in[gi+1] = 31'(61'(ONE30) - (qm_q >> SHF));
    assign hr_out[gi]  = rb_q;
    assign hk_out[gi]  = kb_q;
  end

  // scale by 2^-k, then set up the sigma division
  logic [30:0] e_q;
  logic [31:0] d_q;
  logic [62:0] num_q;
  logic [31:0] e_tmp;
  logic [31:0] d_c;

  assign e_tmp = {pw_in[HORNER_N], 1'b0} >> hk_out[HORNER_N-1];
  assign d_c   = 32'(ONE30) + 32'(e_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q   <= (hk_out[HORNER_N-1] >= K_W'(31)) ? 31'd0 :
               31'(e_tmp >> 1) + 31'(e_tmp[0]);
      d_q   <= d_c;
      num_q <= side_q[ES].sign ? ({e_q, 32'd0} + 63'(d_c >> 1))
                               : ((63'd1 << 62) + 63'(d_c >> 1));
    end
  end

  // restoring divider, one quotient bit per stage
  logic [31:0]         dv_rem [DIV_BITS+1];
  logic [DIV_BITS-1:0] dv_quo [DIV_BITS+1];
  logic [DIV_BITS-1:0] dv_num [DIV_BITS+1];
  logic [31:0]         dv_d   [DIV_BITS+1];

  assign dv_rem[0] = 32'(num_q[62:DIV_BITS]);
  assign dv_quo[0] = '0;
  assign dv_num[0] = num_q[DIV_BITS-1:0];
  assign dv_d[0]   = d_q;

  for (genvar gj = 0; gj < DIV_BITS; gj++) begin : g_div
    logic [32:0]         trial;
    logic                ge;
    logic [31:0]         rem_q, d_q2;
    logic [DIV_BITS-1:0] quo_q, num_q2;
    assign trial = {dv_rem[gj], dv_num[gj][DIV_BITS-1-gj]};
    assign ge    = (trial >= {1'b0, dv_d[gj]});
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q  <= ge ? 32'(trial - {1'b0, dv_d[gj]}) : trial[31:0];
        quo_q  <= {dv_quo[gj][DIV_BITS-2:0], ge};
        num_q2 <= dv_num[gj];
        d_q2   <= dv_d[gj];
      end
    end
    assign dv_rem[gj+1] = rem_q;
    assign dv_quo[gj+1] = quo_q;
    assign dv_num[gj+1] = num_q2;
    assign dv_d[gj+1]   = d_q2;
  end

  // mantissa product and leading-one search
  logic [43:0] mag_q, magb_q;
  logic [5:0]  b_c, b_q;

  always_comb begin
    b_c = '0;
    for (int i = 0; i < 44; i++) begin
      if (mag_q[i]) begin
        b_c = 6'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q  <= 44'(side_q[MS-1].m) * 44'(dv_quo[DIV_BITS]);
      magb_q <= mag_q;
      b_q    <= b_c;
    end
  end

  // pack to half, round to nearest even
  logic [15:0] y_c;

  always_comb begin
    int          eb;
    int          s;
    logic [15:0] ef;
    logic [43:0] shv;
    logic [43:0] mask;
    logic [11:0] man;
    logic        g, sticky, up;
    logic [15:0] bits;
    eb = int'(b_q) + int'(side_q[NST-1].ee) - 43;
    if (eb > 0) begin
      ef = 16'(eb);
      s  = int'(b_q) - 10;
    end else begin
      ef = '0;
      s  = 33 - int'(side_q[NST-1].ee);
    end
    shv    = magb_q >> (s - 1);
    g      = shv[0];
    man    = 12'(shv >> 1);
    mask   = (44'd1 << (s - 1)) - 44'd1;
    sticky = |(magb_q & mask);
    up     = g && (sticky || man[0]);
    bits   = (ef << 10) + 16'(man) + 16'(up);
    if (side_q[NST-1].special) begin
      y_c = side_q[NST-1].spec_val;
    end else if (magb_q == '0) begin
      y_c = {side_q[NST-1].sign, 15'd0};
    end else begin
      y_c = {side_q[NST-1].sign, bits[14:0]};
    end
  end

  assign ob_push = en && side_q[NST-1].valid;
  assign ob_pop  = pop && (ob_cnt_q != 2'd0);
  assign empty   = (ob_cnt_q == 2'd0);
  assign y_half_o   = ob_q[ob_rp_q][16:1];
  assign last_out_o = ob_q[ob_rp_q][0];

  always_comb begin
    ob_cnt_d = ob_cnt_q + 2'(ob_push) - 2'(ob_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wp_q  <= 1'b0;
      ob_rp_q  <= 1'b0;
      ob_cnt_q <= 2'd0;
    end else begin
      ob_wp_q  <= ob_wp_q ^ ob_push;
      ob_rp_q  <= ob_rp_q ^ ob_pop;
      ob_cnt_q <= ob_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ob_push) begin
      ob_q[ob_wp_q] <= {y_c, side_q[NST-1].last};
    end
  end

endmodule

FILE: rtl/core/gelu_fp16_tanh_approx_unit.sv
// GELU, tanh approximation in sigmoid form, on half-precision items: y = x*sigma(z).
// Accepts one item per cycle and delivers one result per cycle when not stalled;
// the pipeline depth is set by the 12-step Horner series for exp (two stages a
// step) and the 33-stage restoring divider for sigma. Queue-style ports on both
// sides; a 4-entry queue separates the decode front from the arithmetic back end.
// Depends on gfu_pkg, gfu_front, gfu_queue, gfu_back.
module gelu_fp16_tanh_approx_unit import gfu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] x_half_i,
  input  logic        last_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] y_half_o,
  output logic        last_out_o
);

  logic  q_full, q_push, q_empty, q_pop;
  item_t f_item, q_item;

  gfu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .x_half_i  (x_half_i),
    .last_in_i (last_in_i),
    .qfull_i   (q_full),
    .qpush_o   (q_push),
    .item_o    (f_item)
  );

  gfu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  gfu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .qempty_i   (q_empty),
    .qitem_i    (q_item),
    .qpop_o     (q_pop),
    .empty      (empty),
    .pop        (pop),
    .y_half_o   (y_half_o),
    .last_out_o (last_out_o)
  );

endmodule

FILE: rtl/core/gfu_checker.sv
// Port-level checks for gelu_fp16_tanh_approx_unit, attached by bind.
// No dependencies beyond the top level's ports.
module gfu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic [15:0] x_half_i,
  input logic        last_in_i,
  input logic        empty,
  input logic        pop,
  input logic [15:0] y_half_o,
  input logic        last_out_o
);

  // first edge out of reset: nothing waiting, room for an item
  a_reset_state: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("not empty or full right after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(y_half_o) && $stable(last_out_o)))
    else $error("waiting result changed before pop");

  // only the canonical NaN ever leaves the block
  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(y_half_o[14:10] == 5'd31 && y_half_o[9:0] != 10'd0 &&
                 y_half_o != 16'h7E00))
    else $error("non-canonical NaN result");

  // negative results are small in magnitude
  a_neg_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && y_half_o[15]) |-> (y_half_o[14:10] < 5'd15))
    else $error("negative result with magnitude of one or more");

endmodule

bind gelu_fp16_tanh_approx_unit gfu_checker u_gfu_checker (.*);
